### design/svsd_pkg.sv
// Shared types and constants for the sample variance / standard deviation block.
// Holds the item structs, error codes, engine state type and default sizes.
// No dependencies; every other file of the block refers to it by scoped names.
package svsd_pkg;

  // Width of one sample as it arrives on the input channel.
  localparam int SAMPLE_BITS = 16;
  // Width of the result value field.
  localparam int VALUE_W = 40;
  // Smallest set that has an unbiased variance.
  localparam int MIN_SET = 2;

  localparam int MAX_COUNT_DEF = 1024;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_FEW  = 2'd1,
    ERR_TOO_MANY = 2'd2
  } err_code_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    err_code_t          error_code;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR_SUM,
    ST_MUL_N_S2,
    ST_NUM_SUB,
    ST_DEN_MUL,
    ST_DEN_SUB,
    ST_DIV,
    ST_SQRT,
    ST_PACK,
    ST_DONE
  } svsd_state_t;

endpackage

### design/svsd_engine.sv
// Iterative arithmetic engine: turns count, |sum| and sum of squares into the
// variance or standard deviation with one shared add/subtract unit.
// Depends on svsd_pkg.
module svsd_engine #(
  parameter int   MAX_COUNT = svsd_pkg::MAX_COUNT_DEF,
  parameter int   FRAC_BITS = svsd_pkg::FRAC_BITS_DEF,
  localparam int  SB        = svsd_pkg::SAMPLE_BITS,
  localparam int  CW        = $clog2(MAX_COUNT + 1),
  localparam int  SQ_W      = 2 * SB - 1,
  localparam int  S2W       = SQ_W + CW,
  localparam int  SABS_W    = SB + CW - 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [CW-1:0]           job_n,
  input  logic [SABS_W-1:0]       job_sabs,
  input  logic [S2W-1:0]          job_s2,
  input  svsd_pkg::err_code_t     job_err,
  input  logic                    job_kind,
  input  logic                    take,
  output logic                    busy,
  output logic                    done,
  output svsd_pkg::out_item_t     result
);

  localparam int NUM_W = S2W + CW;
  localparam int DW    = 2 * CW;
  localparam int QW    = ((NUM_W + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int RW    = QW / 2;
  localparam int REM_W = (DW + 1 > RW + 3) ? DW + 1 : RW + 3;
  localparam int AW    = ((NUM_W > REM_W) ? NUM_W : REM_W) + 1;
  localparam int QR_W  = (NUM_W > RW) ? NUM_W : RW;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int VW    = svsd_pkg::VALUE_W;
  localparam int EXT_W = (QW > VW) ? QW : VW;

  svsd_pkg::svsd_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   kind_r, kind_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [SABS_W-1:0]      sabs_r, sabs_nxt;
  logic [S2W-1:0]         s2_r, s2_nxt;
  logic [SABS_W-1:0]      m_r, m_nxt;
  logic [QW-1:0]          p_r, p_nxt;
  logic [QR_W-1:0]        q_r, q_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  svsd_pkg::out_item_t    res_r, res_nxt;

  // The shared unit: one add/subtract with the sign of the result as compare.
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub;
  logic          alu_ge;

  assign alu_res = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);
  assign alu_ge  = ~alu_res[AW-1];

  logic               m_top;
  logic               last_step;
  logic [REM_W-1:0]   rem_div_sh;
  logic [REM_W-1:0]   rem_sq_sh;
  logic [RW+1:0]      trial;
  logic [NUM_W-1:0]   num;
  logic [EXT_W-1:0]   pack_src;
  logic               pack_sat;

  assign m_top      = m_r[SABS_W-1];
  assign last_step  = (cnt_r == CNT_W'(1));
  assign rem_div_sh = {rem_r[REM_W-2:0], p_r[QW-1]};
  assign rem_sq_sh  = {rem_r[REM_W-3:0], p_r[QW-1:QW-2]};
  assign trial      = {q_r[RW-1:0], 2'b01};
  assign num        = alu_res[NUM_W-1:0];
  assign pack_src   = kind_r ? EXT_W'(q_r[RW-1:0]) : EXT_W'(p_r);
  assign pack_sat   = |(pack_src >> VW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
    n_r    <= n_nxt;
    sabs_r <= sabs_nxt;
    s2_r   <= s2_nxt;
    m_r    <= m_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    n_nxt     = n_r;
    sabs_nxt  = sabs_r;
    s2_nxt    = s2_r;
    m_nxt     = m_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;

    unique case (state_r)
      svsd_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt    = job_n;
          sabs_nxt = job_sabs;
          s2_nxt   = job_s2;
          kind_nxt = job_kind;
          if (job_err != svsd_pkg::ERR_NONE) begin
            res_nxt.result_value = '0;
            res_nxt.error_code   = job_err;
            state_nxt            = svsd_pkg::ST_DONE;
          end else begin
            m_nxt     = job_sabs;
            q_nxt     = '0;
            cnt_nxt   = CNT_W'(SABS_W);
            state_nxt = svsd_pkg::ST_SQR_SUM;
          end
        end
      end

      // Square of |sum|, one multiplier bit per cycle, MSB first.
      svsd_pkg::ST_SQR_SUM: begin
        alu_a   = AW'({q_r[NUM_W-2:0], 1'b0});
        alu_b   = m_top ? AW'(sabs_r) : '0;
        q_nxt   = QR_W'(alu_res[NUM_W-1:0]);
        m_nxt   = {m_r[SABS_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          m_nxt     = {n_r, {(SABS_W - CW){1'b0}}};
          p_nxt     = '0;
          cnt_nxt   = CNT_W'(CW);
          state_nxt = svsd_pkg::ST_MUL_N_S2;
        end
      end

      svsd_pkg::ST_MUL_N_S2: begin
        alu_a   = AW'({p_r[NUM_W-2:0], 1'b0});
        alu_b   = m_top ? AW'(s2_r) : '0;
        p_nxt   = QW'(alu_res[NUM_W-1:0]);
        m_nxt   = {m_r[SABS_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          state_nxt = svsd_pkg::ST_NUM_SUB;
        end
      end

      // The numerator is never negative, so no sign handling is needed.
      // It is pre-scaled here by the fraction bits the division must produce.
      svsd_pkg::ST_NUM_SUB: begin
        alu_a     = AW'(p_r[NUM_W-1:0]);
        alu_b     = AW'(q_r[NUM_W-1:0]);
        alu_sub   = 1'b1;
        p_nxt     = kind_r ? (QW'(num) << (2 * FRAC_BITS)) : (QW'(num) << FRAC_BITS);
        d_nxt     = '0;
        m_nxt     = {n_r, {(SABS_W - CW){1'b0}}};
        cnt_nxt   = CNT_W'(CW);
        state_nxt = svsd_pkg::ST_DEN_MUL;
      end

      svsd_pkg::ST_DEN_MUL: begin
        alu_a   = AW'({d_r[DW-2:0], 1'b0});
        alu_b   = m_top ? AW'(n_r) : '0;
        d_nxt   = alu_res[DW-1:0];
        m_nxt   = {m_r[SABS_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          state_nxt = svsd_pkg::ST_DEN_SUB;
        end
      end

      // n*n - n gives the denominator n*(n-1).
      svsd_pkg::ST_DEN_SUB: begin
        alu_a     = AW'(d_r);
        alu_b     = AW'(n_r);
        alu_sub   = 1'b1;
        d_nxt     = alu_res[DW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(QW);
        state_nxt = svsd_pkg::ST_DIV;
      end

      // Restoring division; quotient bits shift into p as the dividend leaves.
      svsd_pkg::ST_DIV: begin
        alu_a   = AW'(rem_div_sh);
        alu_b   = AW'(d_r);
        alu_sub = 1'b1;
        if (alu_ge) begin
          rem_nxt = alu_res[REM_W-1:0];
          p_nxt   = {p_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_div_sh;
          p_nxt   = {p_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          if (kind_r) begin
            rem_nxt   = '0;
            q_nxt     = '0;
            cnt_nxt   = CNT_W'(RW);
            state_nxt = svsd_pkg::ST_SQRT;
          end else begin
            state_nxt = svsd_pkg::ST_PACK;
          end
        end
      end

      // Digit-by-digit square root, two radicand bits per cycle.
      svsd_pkg::ST_SQRT: begin
        alu_a   = AW'(rem_sq_sh);
        alu_b   = AW'(trial);
        alu_sub = 1'b1;
        if (alu_ge) begin
          rem_nxt = alu_res[REM_W-1:0];
          q_nxt   = QR_W'({q_r[RW-2:0], 1'b1});
        end else begin
          rem_nxt = rem_sq_sh;
          q_nxt   = QR_W'({q_r[RW-2:0], 1'b0});
        end
        p_nxt   = {p_r[QW-3:0], 2'b00};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          state_nxt = svsd_pkg::ST_PACK;
        end
      end

      svsd_pkg::ST_PACK: begin
        res_nxt.result_value = pack_sat ? {VW{1'b1}} : pack_src[VW-1:0];
        res_nxt.error_code   = svsd_pkg::ERR_NONE;
        state_nxt            = svsd_pkg::ST_DONE;
      end

      svsd_pkg::ST_DONE: begin
        if (take) begin
          state_nxt = svsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = svsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_r != svsd_pkg::ST_IDLE);
  assign done   = (state_r == svsd_pkg::ST_DONE);
  assign result = res_r;

  // A set that reaches the divider has at least two samples.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svsd_pkg::ST_DIV) |-> (d_r != '0))
    else $error("divider entered with a zero denominator");

  a_sqrt_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svsd_pkg::ST_SQRT) |-> kind_r)
    else $error("square root ran for a variance request");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (state_r == svsd_pkg::ST_IDLE)) |=> (state_r != svsd_pkg::ST_IDLE))
    else $error("engine did not leave idle after a start");

endmodule

### design/sample_variance_std_dev.sv
// Top level of the unbiased sample variance / standard deviation block.
// Accumulates count, sum and sum of squares and hands each set to svsd_engine.
// Depends on svsd_pkg and svsd_engine.

// Samples are taken one per cycle while the block is accumulating; a sample
// without the last mark causes no result. The item that carries the last mark
// starts the arithmetic engine, and the input stalls until that set's result
// has moved into the output register. The engine uses one add/subtract unit
// bit by bit: with count width CW = clog2(MAX_COUNT+1), sum magnitude width
// SW = SAMPLE_BITS+CW-1 and quotient width QW (numerator width plus twice
// FRAC_BITS, rounded up to even), it squares the SW-bit |sum|, multiplies the
// sum of squares by the count, subtracts, forms n*(n-1), divides to QW quotient
// bits and, for the standard deviation, takes a QW/2-bit root. Sets with an
// error skip the arithmetic. After the result is loaded the next set's samples
// are accepted at once, even while the result still waits on a stalled output.
module sample_variance_std_dev #(
  parameter int MAX_COUNT = svsd_pkg::MAX_COUNT_DEF,
  parameter int FRAC_BITS = svsd_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  svsd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output svsd_pkg::out_item_t  out_item
);

  localparam int SB     = svsd_pkg::SAMPLE_BITS;
  localparam int CW     = $clog2(MAX_COUNT + 1);
  localparam int S1W    = SB + CW;
  localparam int SQ_W   = 2 * SB - 1;
  localparam int S2W    = SQ_W + CW;
  localparam int SABS_W = SB + CW - 1;

  logic                   kind_r;
  logic [CW-1:0]          count_r, count_upd;
  logic signed [S1W-1:0]  sum_r, sum_upd;
  logic [S2W-1:0]         sq_r, sq_upd;
  logic                   ovf_r, ovf_upd;
  logic                   out_valid_r;
  svsd_pkg::out_item_t    out_item_r;

  logic                   in_accept;
  logic                   room;
  logic signed [2*SB-1:0] prod;
  logic [SQ_W-1:0]        sq_val;
  logic [S1W-1:0]         sabs_full;
  svsd_pkg::err_code_t    job_err;

  logic                   eng_start;
  logic                   eng_busy;
  logic                   eng_done;
  logic                   eng_take;
  svsd_pkg::out_item_t    eng_result;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = eng_busy;

  assign room   = (count_r < CW'(MAX_COUNT));
  assign prod   = $signed(in_item.sample) * $signed(in_item.sample);
  assign sq_val = prod[SQ_W-1:0];

  // A sample that arrives with the count already full is dropped and flagged.
  always_comb begin
    count_upd = count_r;
    sum_upd   = sum_r;
    sq_upd    = sq_r;
    ovf_upd   = ovf_r;
    if (room) begin
      count_upd = count_r + CW'(1);
      sum_upd   = sum_r + S1W'($signed(in_item.sample));
      sq_upd    = sq_r + S2W'(sq_val);
    end else begin
      ovf_upd = 1'b1;
    end
  end

  assign sabs_full = sum_upd[S1W-1] ? S1W'(-sum_upd) : S1W'(sum_upd);

  always_comb begin
    priority if (ovf_upd) begin
      job_err = svsd_pkg::ERR_TOO_MANY;
    end else if (count_upd < CW'(svsd_pkg::MIN_SET)) begin
      job_err = svsd_pkg::ERR_TOO_FEW;
    end else begin
      job_err = svsd_pkg::ERR_NONE;
    end
  end

  assign eng_start = in_accept && in_item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= 1'b0;
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kind_r <= cfg_wr_data;
      end
      if (in_accept) begin
        if (in_item.last) begin
          count_r <= '0;
          sum_r   <= '0;
          sq_r    <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= count_upd;
          sum_r   <= sum_upd;
          sq_r    <= sq_upd;
          ovf_r   <= ovf_upd;
        end
      end
    end
  end

  svsd_engine #(
    .MAX_COUNT (MAX_COUNT),
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (eng_start),
    .job_n    (count_upd),
    .job_sabs (sabs_full[SABS_W-1:0]),
    .job_s2   (sq_upd),
    .job_err  (job_err),
    .job_kind (kind_r),
    .take     (eng_take),
    .busy     (eng_busy),
    .done     (eng_done),
    .result   (eng_result)
  );

  // The finished result moves to the output register once that is free.
  assign eng_take = eng_done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      out_item_r <= eng_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.last) |=> in_stall)
    else $error("input not stalled while a set is being computed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.error_code != svsd_pkg::ERR_NONE))
      |-> (out_item.result_value == '0))
    else $error("error result carries a nonzero value");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.last) |=> ((count_r == '0) && !ovf_r))
    else $error("accumulators not cleared after the last item of a set");

endmodule

### tb/tb_sample_variance_std_dev.sv
// Self-checking testbench for sample_variance_std_dev: drives sample sets with random gaps and
// output stalls and checks every result against an in-bench predictor of variance / std dev.
// Depends on svsd_pkg and the sample_variance_std_dev RTL.
module tb_sample_variance_std_dev;

  localparam int  MAX_SAMPLES   = svsd_pkg::MAX_COUNT_DEF;
  localparam int  FRAC          = svsd_pkg::FRAC_BITS_DEF;
  localparam int  SAMPLE_W      = svsd_pkg::SAMPLE_BITS;
  localparam int  SETTLE_CYCLES = 250;
  localparam bit  KIND_VARIANCE = 1'b0;
  localparam bit  KIND_STD_DEV  = 1'b1;
  localparam longint unsigned VALUE_MAX = (64'd1 << svsd_pkg::VALUE_W) - 1;

  // Tracks one set of samples and queues the result the block must produce for it.
  class spread_scoreboard;
    bit                  kind;
    int unsigned         count;
    longint signed       sum;
    longint unsigned     square_sum;
    bit                  overflowed;
    svsd_pkg::out_item_t expected_results[$];
    int                  errors;

    function new();
      kind = KIND_VARIANCE;
      errors = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      sum = 0;
      square_sum = 0;
      overflowed = 1'b0;
    endfunction

    function void set_kind(bit k);
      kind = k;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // floor(num * 2^shift / den); the quotient stays far below 64 bits at these sizes.
    function longint unsigned scaled_quotient(longint unsigned num, longint unsigned den,
                                              int shift);
      longint unsigned q;
      longint unsigned r;
      q = num / den;
      r = num % den;
      return (q << shift) + ((r << shift) / den);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function void take_sample(svsd_pkg::in_item_t it);
      longint signed       s;
      longint unsigned     n;
      longint unsigned     mag;
      longint unsigned     num;
      longint unsigned     value;
      svsd_pkg::out_item_t res;
      s = longint'($signed(it.sample));
      if (count < MAX_SAMPLES) begin
        sum += s;
        square_sum += longint'(s * s);
        count++;
      end else begin
        overflowed = 1'b1;
      end
      if (!it.last) return;
      value = 0;
      if (overflowed) begin
        res.error_code = svsd_pkg::ERR_TOO_MANY;
      end else if (count < svsd_pkg::MIN_SET) begin
        res.error_code = svsd_pkg::ERR_TOO_FEW;
      end else begin
        res.error_code = svsd_pkg::ERR_NONE;
        n = count;
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        num = n * square_sum - mag * mag;
        if (kind == KIND_VARIANCE) value = scaled_quotient(num, n * (n - 1), FRAC);
        else value = floor_sqrt(scaled_quotient(num, n * (n - 1), 2 * FRAC));
        if (value > VALUE_MAX) value = VALUE_MAX;
      end
      res.result_value = value[svsd_pkg::VALUE_W-1:0];
      expected_results.push_back(res);
      clear();
    endfunction

    function void check_result(svsd_pkg::out_item_t got);
      svsd_pkg::out_item_t exp_item;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d err %0d", got.result_value, got.error_code);
        return;
      end
      exp_item = expected_results.pop_front();
      if (got.result_value !== exp_item.result_value || got.error_code !== exp_item.error_code)
      begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected value %0d err %0d, got value %0d err %0d",
                   exp_item.result_value, exp_item.error_code,
                   got.result_value, got.error_code);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  svsd_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  svsd_pkg::out_item_t out_item;

  int gap_pct = 0;
  int stall_pct = 0;
  spread_scoreboard sb = new();

  sample_variance_std_dev u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Inputs only change through nonblocking assignments, so these are the values the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_sample(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  task automatic send_sample(logic signed [svsd_pkg::SAMPLE_BITS-1:0] s, bit last_flag);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{sample: s, last: last_flag};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [svsd_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_set(int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Drops valid, waits for every queued result, then gives the engine time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(bit k);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_kind(k);
  endtask

  task automatic run_directed();
    send_sample(16'sh8000, 1'b1);                 // a single sample is too few
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);                 // widest possible spread
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);                 // equal samples, zero spread
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic run_random(int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1, 2: len = $urandom_range(11, 64);
        default: len = $urandom_range(2, 10);
      endcase
      send_random_set(len);
      sent += len;
    end
  endtask

  initial begin : timeout
    #8000000;
    $display("sample_variance_std_dev test failed");
    $finish;
  end

  initial begin : main
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_kind(KIND_VARIANCE);
    run_directed();
    settle();
    write_kind(KIND_STD_DEV);
    run_directed();
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      write_kind(phase[0] ? KIND_STD_DEV : KIND_VARIANCE);
      run_random(80);
      settle();
    end

    // A set that fills the count and runs one past it, then a short one after it.
    gap_pct = 30;
    stall_pct = 30;
    write_kind(KIND_STD_DEV);
    send_random_set(MAX_SAMPLES + 1);
    send_random_set(3);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sample_variance_std_dev test passed");
    end else begin
      $display("sample_variance_std_dev test failed");
    end
    $finish;
  end

endmodule

### sample_variance_std_dev.f
design/svsd_pkg.sv
design/svsd_engine.sv
design/sample_variance_std_dev.sv
tb/tb_sample_variance_std_dev.sv
